FILE: src/icc_pkg.sv
// Shared constants and types of the interrupt claim controller.
`timescale 1ns / 1ps

package icc_pkg;

	localparam int unsigned SRC_W    = 5;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned ADDR_W   = 32;
	localparam int unsigned OP_W     = 2;
	localparam int unsigned MAX_SRC  = 32;

	localparam logic [OP_W-1:0] OP_BUS_READ  = 2'd0;
	localparam logic [OP_W-1:0] OP_BUS_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_RAISE     = 2'd2;
	localparam logic [OP_W-1:0] OP_CLEAR     = 2'd3;

	// byte offset of the claim/complete register inside the context window
	localparam logic [ADDR_W:0] CLAIM_OFFSET = 33'd4;

	localparam logic [DATA_W-1:0] ENABLE_RESET = 32'hffff_ffff;

	// per-transfer commands broadcast to every cell
	typedef struct packed {
		logic claim_rd;
		logic complete;
		logic raise;
		logic clear;
	} cell_ctl_t;

	// priority and summary chain passed from cell to cell
	typedef struct packed {
		logic found;     // a lower source is eligible now
		logic any_next;  // some lower source is eligible after the update
	} cell_chain_t;

endpackage

FILE: src/icc_channels.sv
// Channel interfaces of the interrupt claim controller.
`timescale 1ns / 1ps

interface icc_cmd_if;
	import icc_pkg::*;
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   op;
	logic [ADDR_W-1:0] bus_address;
	logic [DATA_W-1:0] write_data;
	logic [SRC_W-1:0]  source_number;

	modport source (output valid, op, bus_address, write_data, source_number, input ready);
	modport sink   (input valid, op, bus_address, write_data, source_number, output ready);
endinterface

interface icc_rsp_if;
	import icc_pkg::*;
	logic             valid;
	logic             ready;
	logic [SRC_W-1:0] read_data;
	logic             external_irq;

	modport source (output valid, read_data, external_irq, input ready);
	modport sink   (input valid, read_data, external_irq, output ready);
endinterface

interface icc_cfg_if;
	import icc_pkg::*;
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

FILE: src/interrupt_claim_controller_top.sv
// Top level: command decode, row of source cells, response register.
//
//  channel | dir | payload                                      | transfer when
//  cmd     | in  | op, bus_address, write_data, source_number  | cmd.valid & cmd.ready
//  rsp     | out | read_data, external_irq                      | rsp.valid & rsp.ready
//  cfg     | in  | data (source enable mask)                    | cfg.valid & cfg.ready
//
// One command per cycle while cmd.ready is high; each response is valid the cycle after its command.
// The claim search ripples combinationally through the cell row.
// cmd.ready is high whenever the response register is empty or being taken.
// cfg.ready is always high. Reset clears pending, claimed, line and enables all sources.
`timescale 1ns / 1ps

module interrupt_claim_controller_top
	import icc_pkg::*;
#(
	parameter int unsigned       NUM_SOURCES         = 32,
	parameter logic [ADDR_W-1:0] CONTEXT_WINDOW_BASE = 32'h0020_0000,
	parameter int unsigned       CONTEXT_WINDOW_SIZE = 4096
) (
	input logic      clk,
	input logic      arst_n,
	icc_cmd_if.sink  cmd,
	icc_rsp_if.source rsp,
	icc_cfg_if.sink  cfg
);

	localparam int unsigned NCELL = (NUM_SOURCES >= MAX_SRC) ? MAX_SRC : NUM_SOURCES;

	localparam logic [ADDR_W:0] WIN_LO     = {1'b0, CONTEXT_WINDOW_BASE};
	localparam logic [ADDR_W:0] WIN_HI     = WIN_LO + (ADDR_W+1)'(CONTEXT_WINDOW_SIZE);
	localparam logic [ADDR_W:0] CLAIM_ADDR = WIN_LO + CLAIM_OFFSET;

	logic [DATA_W-1:0] enable_q;
	logic [SRC_W-1:0]  read_data_q;
	logic              rsp_valid_q;
	logic              irq_q;

	logic              accept;
	logic              claim_hit;
	logic [ADDR_W:0]   addr_ext;
	cell_ctl_t         ctl;
	cell_chain_t       chain [NCELL+1];
	logic [NCELL-1:0]  grant;
	logic [SRC_W-1:0]  grant_idx;

	assign cmd.ready = ~rsp_valid_q | rsp.ready;
	assign accept    = cmd.valid & cmd.ready;
	assign cfg.ready = 1'b1;

	assign addr_ext  = {1'b0, cmd.bus_address};
	assign claim_hit = (addr_ext >= WIN_LO) && (addr_ext < WIN_HI) && (addr_ext == CLAIM_ADDR);

	always_comb begin
		ctl = '0;
		if (accept) begin
			unique case (cmd.op)
				OP_BUS_READ:  ctl.claim_rd = claim_hit;
				OP_BUS_WRITE: ctl.complete = claim_hit;
				OP_RAISE:     ctl.raise    = 1'b1;
				OP_CLEAR:     ctl.clear    = 1'b1;
				default:      ctl          = '0;
			endcase
		end
	end

	assign chain[0] = '0;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		icc_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctl          (ctl),
			.enable       (enable_q[i]),
			.event_hit    (cmd.source_number == SRC_W'(i)),
			.complete_hit (cmd.write_data[SRC_W-1:0] == SRC_W'(i)),
			.chain_in     (chain[i]),
			.chain_out    (chain[i+1]),
			.grant        (grant[i])
		);
	end

	// grant is one-hot or empty, so OR the indices together
	always_comb begin
		grant_idx = '0;
		for (int i = 0; i < NCELL; i++) begin
			if (grant[i]) begin
				grant_idx = grant_idx | SRC_W'(i);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= ENABLE_RESET;
		end else if (cfg.valid && cfg.ready) begin
			enable_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_q <= 1'b0;
		end else if (ctl.raise && chain[NCELL].any_next) begin
			irq_q <= 1'b1;
		end else if (ctl.clear && !chain[NCELL].any_next) begin
			irq_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_q <= grant_idx;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.read_data    = read_data_q;
	assign rsp.external_irq = irq_q;

	a_grant_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(grant))
		else $error("more than one source granted in one claim");

	a_rsp_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> rsp_valid_q)
		else $error("accepted command produced no response");

	a_zero_unless_claim: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !ctl.claim_rd |=> read_data_q == '0)
		else $error("nonzero read data without a claim read");

	a_bus_keeps_line: assert property (@(posedge clk) disable iff (!arst_n)
		accept && (cmd.op == OP_BUS_READ || cmd.op == OP_BUS_WRITE) |=> $stable(irq_q))
		else $error("bus access changed the interrupt line");

endmodule

FILE: src/icc_cell.sv
// One interrupt source: pending and claimed bits plus its link in the priority chain.
`timescale 1ns / 1ps

module icc_cell
	import icc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cell_ctl_t   ctl,
	input  logic        enable,
	input  logic        event_hit,
	input  logic        complete_hit,
	input  cell_chain_t chain_in,
	output cell_chain_t chain_out,
	output logic        grant
);

	logic pending_q;
	logic claimed_q;
	logic pending_d;
	logic claimed_d;
	logic eligible;

	assign eligible = enable & pending_q & ~claimed_q;
	// lowest eligible source wins: block if anything below already is eligible
	assign grant    = ctl.claim_rd & eligible & ~chain_in.found;

	always_comb begin
		pending_d = pending_q;
		if (ctl.raise && event_hit) begin
			pending_d = 1'b1;
		end else if (ctl.clear && event_hit) begin
			pending_d = 1'b0;
		end
	end

	always_comb begin
		claimed_d = claimed_q;
		if (grant) begin
			claimed_d = 1'b1;
		end else if (ctl.complete && complete_hit) begin
			claimed_d = 1'b0;
		end
	end

	assign chain_out.found    = chain_in.found | eligible;
	assign chain_out.any_next = chain_in.any_next | (enable & pending_d & ~claimed_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= 1'b0;
			claimed_q <= 1'b0;
		end else begin
			pending_q <= pending_d;
			claimed_q <= claimed_d;
		end
	end

endmodule
